@@ hdl/ptb_pkg.sv @@
// Shared constants and types for the power-of-two timeout bucket core.
package ptb_pkg;

    localparam int NUM_SLOTS_DEF   = 32;
    localparam int ORDER_COUNT_DEF = 8;
    localparam int DEADLINE_W      = 32;
    localparam int SLOT_W          = 5;
    localparam int IN_DATA_W       = 40;
    localparam int OUT_DATA_W      = 8;

    localparam logic CMD_ARM  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_REPORT = 4'b1000
    } ptb_state_t;

endpackage

@@ hdl/ptb_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module ptb_ram
    import ptb_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
)
(
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ptb_file.sv @@
// Bucket code selection from remaining ticks and the bank-select bits.
module ptb_file
    import ptb_pkg::*;
#(
    parameter int ORDER_COUNT = ORDER_COUNT_DEF
)
(
    input  logic [DEADLINE_W-1:0]                ticks,
    input  logic [ORDER_COUNT-1:0]               bank_sel,
    output logic [$clog2(2*ORDER_COUNT+1)-1:0]   code
);

    localparam int BW = $clog2(2*ORDER_COUNT+1);
    localparam int OW = $clog2(ORDER_COUNT);

    logic [OW-1:0] order;

    always_comb
    begin
        order = '0;
        for (int i = 1; i < ORDER_COUNT; i++)
        begin
            if ((ticks >> (i + 1)) != '0)
            begin
                order = OW'(i);
            end
        end
    end

    always_comb
    begin
        if (ticks == '0)
        begin
            code = BW'(2*ORDER_COUNT);
        end
        else
        begin
            code = BW'(order) + (bank_sel[order] ? '0 : BW'(ORDER_COUNT));
        end
    end

endmodule

@@ hdl/power_of_two_timeout_buckets_core.sv @@
// Top level: per-slot deadline timers filed in power-of-two buckets.
// Arm request: result registered on the accepting edge.
// Tick request: walks orders 0..k (k = trailing ones of the old clock, at most
// ORDER_COUNT-1), each walk a pass over all slots through the slot RAM read port, then
// a report scan over the slots emitting one result per abort (one empty result if none).
// Reset: clock and bank bits cleared, per-slot valid flops cleared so all slots idle.
module power_of_two_timeout_buckets_core
    import ptb_pkg::*;
#(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int ORDER_COUNT = ORDER_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // slot[4:0], timeout_ticks[36:5]
    input  logic                  s_tuser,   // cmd[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // aborted_slot[4:0]
    output logic                  m_tuser,   // abort_valid[0]
    output logic                  m_tlast
);

    localparam int SW = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
    localparam int BW = $clog2(2*ORDER_COUNT+1);
    localparam int OW = $clog2(ORDER_COUNT);
    localparam int CW = $clog2(NUM_SLOTS+1);
    localparam int MW = BW + DEADLINE_W;
    localparam logic [BW-1:0] IDLE_CODE = BW'(2*ORDER_COUNT);
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS-1);

    ptb_state_t state_reg, state_next;

    logic [DEADLINE_W-1:0]  clock_reg, clock_next;
    logic [ORDER_COUNT-1:0] bank_reg, bank_next;
    logic [ORDER_COUNT-1:0] mask_reg, mask_next;
    logic [OW-1:0]          order_reg, order_next;
    logic [BW-1:0]          walk_code_reg, walk_code_next;
    logic [SW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          remain_reg, remain_next;
    logic [NUM_SLOTS-1:0]   valid_reg, valid_next;
    logic [NUM_SLOTS-1:0]   abort_reg, abort_next;
    logic                   p_valid_reg, p_valid_next;
    logic                   p_slot_vld_reg, p_slot_vld_next;
    logic [SW-1:0]          p_slot_reg, p_slot_next;

    logic                   m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0]      m_slot_reg, m_slot_next;
    logic                   m_user_reg, m_user_next;
    logic                   m_last_reg, m_last_next;

    logic                   out_free;
    logic                   accept;
    logic [SLOT_W-1:0]      in_slot;
    logic [DEADLINE_W-1:0]  in_ticks;
    logic [31:0]            in_slot_ext;
    logic [31:0]            idx_ext;

    logic                   ram_we;
    logic [SW-1:0]          ram_waddr;
    logic [MW-1:0]          ram_wdata;
    logic [MW-1:0]          ram_rdata;
    logic [BW-1:0]          rd_code;
    logic [DEADLINE_W-1:0]  rd_deadline;

    logic [DEADLINE_W-1:0]  file_ticks;
    logic [BW-1:0]          file_code;
    logic [OW-1:0]          order_inc;

    assign in_slot     = s_tdata[4:0];
    assign in_ticks    = s_tdata[36:5];
    assign in_slot_ext = 32'(in_slot);
    assign idx_ext     = 32'(idx_reg);
    assign rd_code     = ram_rdata[MW-1:DEADLINE_W];
    assign rd_deadline = ram_rdata[DEADLINE_W-1:0];
    assign order_inc   = order_reg + 1'b1;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign file_ticks = (state_reg == ST_IDLE) ? in_ticks : (rd_deadline - clock_reg);

    ptb_file #(
        .ORDER_COUNT (ORDER_COUNT)
    ) u_file (
        .ticks    (file_ticks),
        .bank_sel (bank_reg),
        .code     (file_code)
    );

    ptb_ram #(
        .WIDTH (MW),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        clock_next      = clock_reg;
        bank_next       = bank_reg;
        mask_next       = mask_reg;
        order_next      = order_reg;
        walk_code_next  = walk_code_reg;
        idx_next        = idx_reg;
        remain_next     = remain_reg;
        valid_next      = valid_reg;
        abort_next      = abort_reg;
        p_valid_next    = 1'b0;
        p_slot_vld_next = valid_reg[idx_reg];
        p_slot_next     = idx_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_slot_next     = m_slot_reg;
        m_user_next     = m_user_reg;
        m_last_next     = m_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = p_slot_reg;
        ram_wdata       = {file_code, rd_deadline};

        // walk evaluation of the slot read last cycle
        if (p_valid_reg && p_slot_vld_reg && rd_code == walk_code_reg)
        begin
            ram_we = 1'b1;
            if (rd_deadline == clock_reg || rd_deadline + 1'b1 == clock_reg)
            begin
                ram_wdata             = {IDLE_CODE, rd_deadline};
                abort_next[p_slot_reg] = 1'b1;
                remain_next           = remain_reg + 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == CMD_TICK)
                    begin
                        clock_next     = clock_reg + 1'b1;
                        mask_next      = ORDER_COUNT'(clock_reg ^ (clock_reg + 1'b1));
                        order_next     = '0;
                        walk_code_next = bank_reg[0] ? BW'(ORDER_COUNT) : '0;
                        idx_next       = '0;
                        remain_next    = '0;
                        abort_next     = '0;
                        state_next     = ST_WALK;
                    end
                    else
                    begin
                        m_valid_next = 1'b1;
                        m_slot_next  = '0;
                        m_user_next  = 1'b0;
                        m_last_next  = 1'b1;
                        if (in_slot_ext < 32'(NUM_SLOTS))
                        begin
                            ram_we                        = 1'b1;
                            ram_waddr                     = in_slot_ext[SW-1:0];
                            ram_wdata                     = {file_code, clock_reg + in_ticks};
                            valid_next[in_slot_ext[SW-1:0]] = 1'b1;
                        end
                    end
                end
            end
            ST_WALK:
            begin
                p_valid_next = 1'b1;
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                bank_next[order_reg] = !bank_reg[order_reg];
                mask_next            = mask_reg >> 1;
                idx_next             = '0;
                if (mask_reg[1])
                begin
                    order_next     = order_inc;
                    walk_code_next = BW'(order_inc)
                                     + (bank_reg[order_inc] ? BW'(ORDER_COUNT) : '0);
                    state_next     = ST_WALK;
                end
                else
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (remain_reg == '0)
                begin
                    if (out_free)
                    begin
                        m_valid_next = 1'b1;
                        m_slot_next  = '0;
                        m_user_next  = 1'b0;
                        m_last_next  = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else if (abort_reg[idx_reg])
                begin
                    if (out_free)
                    begin
                        m_valid_next = 1'b1;
                        m_slot_next  = idx_ext[SLOT_W-1:0];
                        m_user_next  = 1'b1;
                        m_last_next  = (remain_reg == CW'(1));
                        remain_next  = remain_reg - 1'b1;
                        idx_next     = idx_reg + 1'b1;
                        if (remain_reg == CW'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            clock_reg   <= '0;
            bank_reg    <= '0;
            valid_reg   <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            mask_reg    <= '0;
            order_reg   <= '0;
            idx_reg     <= '0;
            remain_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clock_reg   <= clock_next;
            bank_reg    <= bank_next;
            valid_reg   <= valid_next;
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
            mask_reg    <= mask_next;
            order_reg   <= order_next;
            idx_reg     <= idx_next;
            remain_reg  <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_code_reg  <= walk_code_next;
        abort_reg      <= abort_next;
        p_slot_vld_reg <= p_slot_vld_next;
        p_slot_reg     <= p_slot_next;
        m_slot_reg     <= m_slot_next;
        m_user_reg     <= m_user_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'(m_slot_reg);
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ dv/power_of_two_timeout_buckets_core_tb.sv @@
// Self-checking testbench for the timeout bucket core: stimulus, predictor, abort checker.
module power_of_two_timeout_buckets_core_tb;
    import ptb_pkg::*;

    localparam int NSLOT       = NUM_SLOTS_DEF;
    localparam int NORDER      = ORDER_COUNT_DEF;
    localparam logic [SLOT_W-1:0] IDLE_BUCKET = SLOT_W'(2 * ORDER_COUNT_DEF);

    typedef struct packed {
        logic                  cmd;
        logic [SLOT_W-1:0]     slot;
        logic [DEADLINE_W-1:0] ticks;
    } timer_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              last;
    } abort_rec_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    timer_req_t timer_requests[$];
    abort_rec_t expected_aborts[$];
    int         queued_count   = 0;
    int         accepted_count = 0;
    int         error_count    = 0;
    int         send_idle_pct  = 0;
    int         recv_idle_pct  = 0;

    // predictor state
    logic [DEADLINE_W-1:0] timer_clock;
    logic [NORDER-1:0]     bank_bits;
    logic [DEADLINE_W-1:0] slot_due [NSLOT];
    logic [SLOT_W-1:0]     slot_code [NSLOT];

    power_of_two_timeout_buckets_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    task automatic clear_timers();
        timer_clock = '0;
        bank_bits   = '0;
        for (int s = 0; s < NSLOT; s++)
        begin
            slot_due[s]  = '0;
            slot_code[s] = IDLE_BUCKET;
        end
    endtask

    task automatic file_timer(input int s, input logic [DEADLINE_W-1:0] ticks);
        int ord;
        slot_due[s] = timer_clock + ticks;
        if (ticks == '0)
        begin
            slot_code[s] = IDLE_BUCKET;
        end
        else
        begin
            ord = NORDER - 1;
            while (ord > 0 && ticks < (32'd1 << (ord + 1)))
                ord--;
            slot_code[s] = bank_bits[ord] ? SLOT_W'(ord) : SLOT_W'(ord + NORDER);
        end
    endtask

    task automatic predict_aborts(input timer_req_t req);
        logic [DEADLINE_W-1:0] toggled;
        logic [NSLOT-1:0]      aborted;
        logic [NSLOT-1:0]      member;
        logic [SLOT_W-1:0]     code;
        int                    hits;
        int                    n;
        aborted = '0;
        if (req.cmd == CMD_ARM)
        begin
            if (int'(req.slot) < NSLOT)
                file_timer(int'(req.slot), req.ticks);
        end
        else
        begin
            toggled     = timer_clock;
            timer_clock = timer_clock + 32'd1;
            toggled     = toggled ^ timer_clock;
            for (int o = 0; o < NORDER; o++)
            begin
                if (toggled[o])
                begin
                    code = bank_bits[o] ? SLOT_W'(o + NORDER) : SLOT_W'(o);
                    for (int s = 0; s < NSLOT; s++)
                        member[s] = (slot_code[s] == code);
                    for (int s = 0; s < NSLOT; s++)
                    begin
                        if (member[s])
                        begin
                            slot_code[s] = IDLE_BUCKET;
                            if (slot_due[s] != timer_clock && slot_due[s] + 32'd1 != timer_clock)
                                file_timer(s, slot_due[s] - timer_clock);
                            else
                                aborted[s] = 1'b1;
                        end
                    end
                    bank_bits[o] = ~bank_bits[o];
                end
            end
        end
        hits = $countones(aborted);
        if (hits == 0)
        begin
            expected_aborts.push_back('{slot: '0, hit: 1'b0, last: 1'b1});
        end
        else
        begin
            n = 0;
            for (int s = 0; s < NSLOT; s++)
            begin
                if (aborted[s])
                begin
                    n++;
                    expected_aborts.push_back('{slot: SLOT_W'(s), hit: 1'b1, last: (n == hits)});
                end
            end
        end
    endtask

    // request driver
    always @(posedge clk)
    begin : drive_requests
        timer_req_t next_req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                void'(timer_requests.pop_front());
            if (timer_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = timer_requests[0];
                s_tdata  <= {{(IN_DATA_W - SLOT_W - DEADLINE_W){1'b0}}, next_req.ticks,
                             next_req.slot};
                s_tuser  <= next_req.cmd;
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker, then prediction for the request accepted on this edge
    always @(posedge clk)
    begin : check_results
        abort_rec_t exp_rec;
        timer_req_t req;
        if (!rst_n)
        begin
            clear_timers();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_aborts.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result tdata=%0h tuser=%0b tlast=%0b",
                                              m_tdata, m_tuser, m_tlast));
                end
                else
                begin
                    exp_rec = expected_aborts.pop_front();
                    if (m_tdata !== {{(OUT_DATA_W - SLOT_W){1'b0}}, exp_rec.slot})
                        report_mismatch($sformatf("aborted_slot %0h, expected %0d",
                                                  m_tdata, exp_rec.slot));
                    if (m_tuser !== exp_rec.hit)
                        report_mismatch($sformatf("abort_valid %0b, expected %0b",
                                                  m_tuser, exp_rec.hit));
                    if (m_tlast !== exp_rec.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  m_tlast, exp_rec.last));
                end
            end
            if (s_tvalid && s_tready)
            begin
                req.cmd   = s_tuser;
                req.slot  = s_tdata[SLOT_W-1:0];
                req.ticks = s_tdata[SLOT_W+DEADLINE_W-1:SLOT_W];
                predict_aborts(req);
                accepted_count++;
            end
        end
    end

    task automatic push_request(input logic cmd, input logic [SLOT_W-1:0] slot,
                                input logic [DEADLINE_W-1:0] ticks);
        timer_requests.push_back('{cmd: cmd, slot: slot, ticks: ticks});
        queued_count++;
    endtask

    task automatic add_random_requests(input int count);
        int                    sel;
        logic [DEADLINE_W-1:0] ticks;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(99) < 55)
            begin
                // slot and timeout are don't-care on a tick; fill them with noise
                push_request(CMD_TICK, SLOT_W'($urandom_range(NSLOT - 1)), $urandom());
            end
            else
            begin
                sel = $urandom_range(99);
                if (sel < 60)
                    ticks = $urandom_range(1, 40);
                else if (sel < 75)
                    ticks = $urandom_range(41, 600);
                else if (sel < 85)
                    ticks = '0;
                else if (sel < 92)
                    ticks = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 32'd1;
                else
                    ticks = $urandom();
                push_request(CMD_ARM, SLOT_W'($urandom_range(NSLOT - 1)), ticks);
            end
        end
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || expected_aborts.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 0: sender idles 25%, receiver 46%
        send_idle_pct = 25;
        recv_idle_pct = 46;
        push_request(CMD_TICK, 5'd31, 32'hFFFF_FFFF);     // empty walk
        push_request(CMD_ARM, 5'd0, 32'd1);               // smallest timeout
        push_request(CMD_ARM, 5'd31, 32'hFFFF_FFFF);      // deadline wraps to clock - 1
        push_request(CMD_ARM, 5'd5, 32'd2);
        push_request(CMD_ARM, 5'd6, 32'd3);
        push_request(CMD_ARM, 5'd7, 32'd4);
        push_request(CMD_ARM, 5'd8, 32'd255);
        push_request(CMD_ARM, 5'd9, 32'd256);
        push_request(CMD_ARM, 5'd10, 32'd0);              // disarm an idle slot
        push_request(CMD_ARM, 5'd11, 32'd6);
        push_request(CMD_ARM, 5'd11, 32'd0);              // disarm an armed slot
        push_request(CMD_ARM, 5'd20, 32'd2);              // several aborts in one tick
        push_request(CMD_ARM, 5'd3, 32'd2);
        push_request(CMD_ARM, 5'd12, 32'd3);
        push_request(CMD_ARM, 5'd16, 32'h8000_0000);
        for (int k = 0; k < 10; k++)
            push_request(CMD_TICK, 5'd0, 32'd0);
        add_random_requests(160);
        wait_drained();

        // phase 1: roles swapped
        send_idle_pct = 46;
        recv_idle_pct = 25;
        add_random_requests(160);
        wait_drained();

        // phase 2: no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_requests(160);
        wait_drained();

        repeat (400) @(posedge clk);
        if (error_count == 0 && expected_aborts.size() == 0)
            $display("** power_of_two_timeout_buckets_core: PASSED **");
        else
            $display("** power_of_two_timeout_buckets_core: FAILED **");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("** power_of_two_timeout_buckets_core: FAILED **");
        $finish;
    end

endmodule

@@ power_of_two_timeout_buckets_core.f @@
hdl/ptb_pkg.sv
hdl/ptb_ram.sv
hdl/ptb_file.sv
hdl/power_of_two_timeout_buckets_core.sv
dv/power_of_two_timeout_buckets_core_tb.sv
